// ===== rtl/core/pdpr_pkg.sv =====
// ----------------------------------------------------------------------------
// pdpr_pkg
// Shared types and constants of the planar delta pixel reconstruction block.
// ----------------------------------------------------------------------------
package pdpr_pkg;

    localparam int LANE_W     = 8;
    localparam int NUM_LANES  = 4;
    localparam int WORD_W     = LANE_W * NUM_LANES;

    // Lane order inside a stored pixel word
    localparam int LANE_BLUE  = 0;
    localparam int LANE_GREEN = 1;
    localparam int LANE_RED   = 2;
    localparam int LANE_ALPHA = 3;

    localparam int CFG_WIDTH_W  = 13;
    localparam int CFG_HEIGHT_W = 16;
    localparam int ROW_W        = 16;
    localparam int APB_ADDR_W   = 4;
    localparam int APB_DATA_W   = 32;

    localparam logic [LANE_W-1:0] ALPHA_OPAQUE = 8'hFF;

    typedef logic [WORD_W-1:0] word_t;

    typedef enum logic [1:0] {
        REG_IMAGE_WIDTH  = 2'd0,
        REG_IMAGE_HEIGHT = 2'd1,
        REG_USE_ALPHA    = 2'd2
    } reg_index_t;

    // Control carried alongside a request in the line store read stage
    typedef struct packed {
        logic valid;
        logic ovf;
        logic last;
        logic add_above;
        logic alpha_on;
    } stage_ctrl_t;

endpackage

// ===== rtl/core/planar_delta_pixel_reconstruct_unit.sv =====
// ----------------------------------------------------------------------------
// planar_delta_pixel_reconstruct_unit
// Per-pixel planar delta reconstruction with a row sum and a line store.
// ----------------------------------------------------------------------------
// An accepted pixel request passes the stage 1 register, then the output
// register. Throughput: one pixel per cycle unless a held result stalls; the
// line store does at most one read and one write per cycle; row sum is 8-bit.
// Reset: counters, row sum, pipeline valids and configuration registers go to
// their reset values at once; the line store is not cleared (no clearing pass).
// ----------------------------------------------------------------------------
module planar_delta_pixel_reconstruct_unit
    import pdpr_pkg::*;
#(
    parameter int MAX_WIDTH = 4096
)
(
    input  logic                  clk,
    input  logic                  rst_n,

    // configuration port
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [APB_ADDR_W-1:0] paddr,
    input  logic [APB_DATA_W-1:0] pwdata,
    output logic [APB_DATA_W-1:0] prdata,
    output logic                  pready,

    // pixel request channel
    input  logic                  pixel_valid,
    output logic                  pixel_stall,
    input  logic [LANE_W-1:0]     blue_delta,
    input  logic [LANE_W-1:0]     green_delta,
    input  logic [LANE_W-1:0]     red_delta,
    input  logic [LANE_W-1:0]     alpha_delta,
    input  logic                  image_start,

    // result channel
    output logic                  result_valid,
    input  logic                  result_stall,
    output logic [LANE_W-1:0]     red_out,
    output logic [LANE_W-1:0]     green_out,
    output logic [LANE_W-1:0]     blue_out,
    output logic [LANE_W-1:0]     alpha_out,
    output logic                  last_pixel,
    output logic                  overflow_error
);

    localparam int ADDR_W = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
    // compare width covers both the width register and MAX_WIDTH itself
    localparam int CMP_W  = (ADDR_W + 1 > CFG_WIDTH_W) ? ADDR_W + 1 : CFG_WIDTH_W;

    // ------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------
    logic [CFG_WIDTH_W-1:0]  image_width_reg;
    logic [CFG_HEIGHT_W-1:0] image_height_reg;
    logic                    use_alpha_reg;
    logic                    cfg_wr;
    reg_index_t              cfg_idx;

    assign pready  = 1'b1;
    assign cfg_wr  = psel && penable && pwrite && pready;
    assign cfg_idx = reg_index_t'(paddr[3:2]);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            image_width_reg  <= CFG_WIDTH_W'(1);
            image_height_reg <= CFG_HEIGHT_W'(1);
            use_alpha_reg    <= 1'b0;
        end
        else if (cfg_wr)
        begin
            case (cfg_idx)
                REG_IMAGE_WIDTH:  image_width_reg  <= pwdata[CFG_WIDTH_W-1:0];
                REG_IMAGE_HEIGHT: image_height_reg <= pwdata[CFG_HEIGHT_W-1:0];
                REG_USE_ALPHA:    use_alpha_reg    <= pwdata[0];
                default:          ;
            endcase
        end
    end

    always_comb
    begin
        case (cfg_idx)
            REG_IMAGE_WIDTH:  prdata = APB_DATA_W'(image_width_reg);
            REG_IMAGE_HEIGHT: prdata = APB_DATA_W'(image_height_reg);
            REG_USE_ALPHA:    prdata = APB_DATA_W'(use_alpha_reg);
            default:          prdata = '0;
        endcase
    end

    // ------------------------------------------------------------------
    // Pipeline advance: both stages move unless a held result is stalled
    // ------------------------------------------------------------------
    logic adv;
    logic accept;
    logic result_valid_reg;

    assign adv         = !(result_valid_reg && result_stall);
    assign pixel_stall = !adv;
    assign accept      = pixel_valid && !pixel_stall;

    // ------------------------------------------------------------------
    // Stage 0: position tracking and horizontal sum
    // ------------------------------------------------------------------
    logic [ADDR_W-1:0] col_cnt_reg, col_cnt_next;
    logic [ROW_W-1:0]  row_cnt_reg, row_cnt_next;
    word_t             row_sum_reg, row_sum_next;

    logic [CMP_W-1:0]  w_cfg;
    logic [CMP_W-1:0]  w_eff;
    logic [ADDR_W-1:0] cc;
    logic [ROW_W-1:0]  rc;
    word_t             rs;
    logic              wrap;
    logic [ADDR_W-1:0] col;
    logic [ROW_W:0]    row;
    logic [ROW_W:0]    row_inc;
    logic [ROW_W:0]    h_ext;
    logic [CMP_W-1:0]  col_inc;
    logic              col_end;
    logic              ovf;
    logic              last;
    word_t             plane_word;
    word_t             sum_word;

    assign w_cfg = CMP_W'(image_width_reg);
    assign w_eff = (w_cfg > CMP_W'(MAX_WIDTH)) ? CMP_W'(MAX_WIDTH) : w_cfg;
    assign h_ext = {1'b0, image_height_reg};

    // image start clears position and row sum before this pixel is placed
    assign cc = image_start ? '0 : col_cnt_reg;
    assign rc = image_start ? '0 : row_cnt_reg;
    assign rs = image_start ? '0 : row_sum_reg;

    // a column left past a narrowed width starts the next row
    assign wrap    = (w_eff != '0) && (CMP_W'(cc) >= w_eff);
    assign col     = wrap ? '0 : cc;
    assign row     = {1'b0, rc} + (ROW_W + 1)'(wrap);
    assign row_inc = row + (ROW_W + 1)'(1);
    assign col_inc = CMP_W'(col) + CMP_W'(1);
    assign col_end = col_inc >= w_eff;
    assign ovf     = (w_eff == '0) || (row >= h_ext);
    assign last    = (col_inc == w_eff) && (row_inc == h_ext);

    assign plane_word[LANE_BLUE*LANE_W +: LANE_W]  = blue_delta;
    assign plane_word[LANE_GREEN*LANE_W +: LANE_W] = green_delta;
    assign plane_word[LANE_RED*LANE_W +: LANE_W]   = red_delta;
    assign plane_word[LANE_ALPHA*LANE_W +: LANE_W] = use_alpha_reg ? alpha_delta
                                                                   : ALPHA_OPAQUE;

    always_comb
    begin
        col_cnt_next = col_cnt_reg;
        row_cnt_next = row_cnt_reg;
        row_sum_next = row_sum_reg;
        if (accept)
        begin
            if (image_start)
            begin
                col_cnt_next = '0;
                row_cnt_next = '0;
                row_sum_next = '0;
            end
            // pixel outside the image leaves the state untouched but for an image start
            if (!ovf)
            begin
                row_sum_next = sum_word;
                if (col_end)
                begin
                    col_cnt_next = '0;
                    row_cnt_next = row_inc[ROW_W-1:0];
                end
                else
                begin
                    col_cnt_next = col_inc[ADDR_W-1:0];
                    row_cnt_next = row[ROW_W-1:0];
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_cnt_reg <= '0;
            row_cnt_reg <= '0;
            row_sum_reg <= '0;
        end
        else
        begin
            col_cnt_reg <= col_cnt_next;
            row_cnt_reg <= row_cnt_next;
            row_sum_reg <= row_sum_next;
        end
    end

    // ------------------------------------------------------------------
    // Stage 1: line store read returns, vertical add
    // ------------------------------------------------------------------
    stage_ctrl_t       s1_reg, s1_next;
    word_t             s1_sum_reg;
    logic [ADDR_W-1:0] s1_col_reg;
    word_t             above_word;
    word_t             res_word;
    word_t             store_word;
    logic              ls_wr_en;

    always_comb
    begin
        s1_next           = s1_reg;
        if (adv)
        begin
            s1_next.valid     = accept;
            s1_next.ovf       = ovf;
            s1_next.last      = last && !ovf;
            s1_next.add_above = (row != '0);
            s1_next.alpha_on  = use_alpha_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_reg <= '0;
        end
        else
        begin
            s1_reg <= s1_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s1_sum_reg <= sum_word;
            s1_col_reg <= col;
        end
    end

    // the four channel lanes, side by side
    for (genvar i = 0; i < NUM_LANES; i++)
    begin : g_lane
        pdpr_lane u_lane (
            .plane     (plane_word[i*LANE_W +: LANE_W]),
            .green     (green_delta),
            .add_green ((i == LANE_BLUE) || (i == LANE_RED)),
            .row_first (col == '0),
            .row_sum   (rs[i*LANE_W +: LANE_W]),
            .sum       (sum_word[i*LANE_W +: LANE_W]),
            .sum_s1    (s1_sum_reg[i*LANE_W +: LANE_W]),
            .above     (above_word[i*LANE_W +: LANE_W]),
            .add_above (s1_reg.add_above),
            .res       (res_word[i*LANE_W +: LANE_W])
        );
    end

    // merge: alpha forced opaque when the alpha plane is off
    assign store_word = s1_reg.alpha_on ? res_word
                      : {ALPHA_OPAQUE, res_word[LANE_ALPHA*LANE_W-1:0]};

    assign ls_wr_en = adv && s1_reg.valid && !s1_reg.ovf;

    pdpr_line_store #(
        .DEPTH  (MAX_WIDTH),
        .ADDR_W (ADDR_W)
    ) u_line_store (
        .clk     (clk),
        .rst_n   (rst_n),
        .rd_en   (adv),
        .rd_addr (col),
        .rd_data (above_word),
        .wr_en   (ls_wr_en),
        .wr_addr (s1_col_reg),
        .wr_data (store_word)
    );

    // ------------------------------------------------------------------
    // Output register
    // ------------------------------------------------------------------
    word_t out_word_reg;
    logic  last_reg;
    logic  ovf_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            result_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            result_valid_reg <= s1_reg.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            out_word_reg <= s1_reg.ovf ? '0 : store_word;
            last_reg     <= s1_reg.last;
            ovf_reg      <= s1_reg.ovf;
        end
    end

    assign result_valid   = result_valid_reg;
    assign blue_out       = out_word_reg[LANE_BLUE*LANE_W +: LANE_W];
    assign green_out      = out_word_reg[LANE_GREEN*LANE_W +: LANE_W];
    assign red_out        = out_word_reg[LANE_RED*LANE_W +: LANE_W];
    assign alpha_out      = out_word_reg[LANE_ALPHA*LANE_W +: LANE_W];
    assign last_pixel     = last_reg;
    assign overflow_error = ovf_reg;

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    // an out-of-image pixel carries no color and is never the last pixel
    a_ovf_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && overflow_error) |->
            (red_out == '0 && green_out == '0 && blue_out == '0 &&
             alpha_out == '0 && !last_pixel))
        else $error("overflow result not zeroed");

    // the line store is never written while the pipeline is held
    a_no_wr_stalled: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && result_stall) |-> !ls_wr_en)
        else $error("line store write during stall");

    // a request in stage 1 reaches the output on the next advance
    a_s1_to_out: assert property (@(posedge clk) disable iff (!rst_n)
        (adv && s1_reg.valid) |=> result_valid)
        else $error("stage 1 request lost");

endmodule

// ===== rtl/core/pdpr_lane.sv =====
// ----------------------------------------------------------------------------
// pdpr_lane
// One 8-bit channel: decorrelation, horizontal running sum, vertical add.
// ----------------------------------------------------------------------------
module pdpr_lane
    import pdpr_pkg::*;
(
    input  logic [LANE_W-1:0] plane,
    input  logic [LANE_W-1:0] green,
    input  logic              add_green,
    input  logic              row_first,
    input  logic [LANE_W-1:0] row_sum,
    output logic [LANE_W-1:0] sum,
    input  logic [LANE_W-1:0] sum_s1,
    input  logic [LANE_W-1:0] above,
    input  logic              add_above,
    output logic [LANE_W-1:0] res
);

    logic [LANE_W-1:0] pix;

    // all adds wrap modulo 256
    assign pix = add_green ? (plane + green) : plane;
    assign sum = (row_first ? '0 : row_sum) + pix;
    assign res = sum_s1 + (add_above ? above : '0);

endmodule

// ===== rtl/core/pdpr_line_store.sv =====
// ----------------------------------------------------------------------------
// pdpr_line_store
// Previous-row pixel memory, registered read, write-to-read bypass.
// ----------------------------------------------------------------------------
module pdpr_line_store
    import pdpr_pkg::*;
#(
    parameter int DEPTH  = 4096,
    parameter int ADDR_W = 12
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              rd_en,
    input  logic [ADDR_W-1:0] rd_addr,
    output word_t             rd_data,
    input  logic              wr_en,
    input  logic [ADDR_W-1:0] wr_addr,
    input  word_t             wr_data
);

    word_t mem [DEPTH];
    word_t ram_q_reg;
    word_t byp_data_reg;
    logic  byp_hit_reg;
    logic  byp_hit_next;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            ram_q_reg    <= mem[rd_addr];
            byp_data_reg <= wr_data;
        end
    end

    // same-cycle write to the address being read: take the new word
    assign byp_hit_next = rd_en ? (wr_en && (wr_addr == rd_addr)) : byp_hit_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            byp_hit_reg <= 1'b0;
        end
        else
        begin
            byp_hit_reg <= byp_hit_next;
        end
    end

    assign rd_data = byp_hit_reg ? byp_data_reg : ram_q_reg;

endmodule

// ===== tb/testbench.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the planar delta pixel reconstruction unit.
// A cycle-free predictor rebuilds every pixel from the plane bytes, with its
// own row sum and line store. Each result leaving the block is compared
// field by field with the oldest predicted pixel. Both the request side and
// the result side insert random gaps and stalls. The image geometry and the
// alpha mode are rewritten over the APB port between idle phases.
// ----------------------------------------------------------------------------
module testbench;
    import pdpr_pkg::*;

    localparam int LINE_DEPTH   = 4096;  // block's MAX_WIDTH
    localparam int RANDOM_ITEMS = 950;
    localparam int PHASE_CAP    = 120;   // cap on a random phase's pixel count, before up to 3 extra

    typedef struct packed {
        logic [LANE_W-1:0] red;
        logic [LANE_W-1:0] green;
        logic [LANE_W-1:0] blue;
        logic [LANE_W-1:0] alpha;
        logic              last;
        logic              ovf;
    } pixel_result_t;

    // ------------------------------------------------------------------------
    // Scoreboard: pixel predictor plus the queue of predicted results
    // ------------------------------------------------------------------------
    class pixel_scoreboard;
        logic [CFG_WIDTH_W-1:0]  width_reg;
        logic [CFG_HEIGHT_W-1:0] height_reg;
        logic                    alpha_on;
        word_t                   line_mem [LINE_DEPTH];
        bit                      line_set [LINE_DEPTH];
        word_t                   row_acc;
        int unsigned             col_cnt;
        int unsigned             row_cnt;
        pixel_result_t           expected_pixels [$];
        int                      errors;

        function new();
            width_reg  = 1;
            height_reg = 1;
            alpha_on   = 1'b0;
            row_acc    = '0;
            col_cnt    = 0;
            row_cnt    = 0;
            errors     = 0;
            foreach (line_set[i])
                line_set[i] = 1'b0;
        endfunction

        function void set_reg(reg_index_t idx, logic [APB_DATA_W-1:0] value);
            case (idx)
                REG_IMAGE_WIDTH:  width_reg  = value[CFG_WIDTH_W-1:0];
                REG_IMAGE_HEIGHT: height_reg = value[CFG_HEIGHT_W-1:0];
                REG_USE_ALPHA:    alpha_on   = value[0];
                default: ;
            endcase
        endfunction

        function int unsigned eff_width();
            return (width_reg > LINE_DEPTH) ? LINE_DEPTH : width_reg;
        endfunction

        // Position the next request lands on, with the row wrap that follows
        // a width cut; beyond is set when the pixel lies outside the image.
        function void locate(bit start, output int unsigned col,
                             output int unsigned row, output bit beyond);
            int unsigned w;
            w   = eff_width();
            col = start ? 0 : col_cnt;
            row = start ? 0 : row_cnt;
            if (w != 0 && col >= w)
            begin
                col = 0;
                row++;
            end
            beyond = (w == 0) || (row >= height_reg);
        endfunction

        // True when this request would read a line store entry never written
        function bit hits_blank_line(bit start);
            int unsigned col, row;
            bit beyond;
            locate(start, col, row, beyond);
            return !beyond && row > 0 && !line_set[col];
        endfunction

        function word_t lanes_add(word_t x, word_t y);
            word_t s;
            for (int i = 0; i < NUM_LANES; i++)
                s[i*LANE_W +: LANE_W] = x[i*LANE_W +: LANE_W] + y[i*LANE_W +: LANE_W];
            return s;
        endfunction

        function void note_request(logic [LANE_W-1:0] b, logic [LANE_W-1:0] g,
                                   logic [LANE_W-1:0] r, logic [LANE_W-1:0] a,
                                   bit start);
            int unsigned   col, row, w;
            bit            beyond;
            word_t         pix, sum, res;
            pixel_result_t exp_px;
            w = eff_width();
            locate(start, col, row, beyond);
            if (start)
            begin
                col_cnt = 0;
                row_cnt = 0;
                row_acc = '0;
            end
            if (beyond)
            begin
                exp_px     = '0;
                exp_px.ovf = 1'b1;
                expected_pixels.push_back(exp_px);
                return;
            end
            pix[LANE_BLUE*LANE_W  +: LANE_W] = b + g;
            pix[LANE_GREEN*LANE_W +: LANE_W] = g;
            pix[LANE_RED*LANE_W   +: LANE_W] = r + g;
            pix[LANE_ALPHA*LANE_W +: LANE_W] = alpha_on ? a : ALPHA_OPAQUE;
            sum = lanes_add((col == 0) ? word_t'(0) : row_acc, pix);
            res = sum;
            if (row > 0)
                res = lanes_add(res, line_mem[col]);
            if (!alpha_on)
                res[LANE_ALPHA*LANE_W +: LANE_W] = ALPHA_OPAQUE;
            line_mem[col] = res;
            line_set[col] = 1'b1;
            row_acc       = sum;
            exp_px.red   = res[LANE_RED*LANE_W   +: LANE_W];
            exp_px.green = res[LANE_GREEN*LANE_W +: LANE_W];
            exp_px.blue  = res[LANE_BLUE*LANE_W  +: LANE_W];
            exp_px.alpha = res[LANE_ALPHA*LANE_W +: LANE_W];
            exp_px.last  = (col + 1 == w) && (row + 1 == height_reg);
            exp_px.ovf   = 1'b0;
            expected_pixels.push_back(exp_px);
            if (col + 1 >= w)
            begin
                col_cnt = 0;
                row_cnt = row + 1;
            end
            else
            begin
                col_cnt = col + 1;
                row_cnt = row;
            end
        endfunction

        function void compare(string name, int unsigned expv, int unsigned actv);
            if (expv != actv)
            begin
                $error("%s: expected %0d, got %0d", name, expv, actv);
                errors++;
            end
        endfunction

        function void check_result(pixel_result_t got);
            pixel_result_t exp_px;
            if (expected_pixels.size() == 0)
            begin
                $error("result with no pixel pending");
                errors++;
                return;
            end
            exp_px = expected_pixels.pop_front();
            compare("red_out",        exp_px.red,   got.red);
            compare("green_out",      exp_px.green, got.green);
            compare("blue_out",       exp_px.blue,  got.blue);
            compare("alpha_out",      exp_px.alpha, got.alpha);
            compare("last_pixel",     exp_px.last,  got.last);
            compare("overflow_error", exp_px.ovf,   got.ovf);
        endfunction

        function int pending();
            return expected_pixels.size();
        endfunction
    endclass

    // ------------------------------------------------------------------------
    // DUT hookup
    // ------------------------------------------------------------------------
    logic                  clk;
    logic                  rst_n;
    logic                  psel;
    logic                  penable;
    logic                  pwrite;
    logic [APB_ADDR_W-1:0] paddr;
    logic [APB_DATA_W-1:0] pwdata;
    logic [APB_DATA_W-1:0] prdata;
    logic                  pready;
    logic                  pixel_valid;
    logic                  pixel_stall;
    logic [LANE_W-1:0]     blue_delta;
    logic [LANE_W-1:0]     green_delta;
    logic [LANE_W-1:0]     red_delta;
    logic [LANE_W-1:0]     alpha_delta;
    logic                  image_start;
    logic                  result_valid;
    logic                  result_stall;
    logic [LANE_W-1:0]     red_out;
    logic [LANE_W-1:0]     green_out;
    logic [LANE_W-1:0]     blue_out;
    logic [LANE_W-1:0]     alpha_out;
    logic                  last_pixel;
    logic                  overflow_error;

    planar_delta_pixel_reconstruct_unit #(
        .MAX_WIDTH (LINE_DEPTH)
    ) dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .psel           (psel),
        .penable        (penable),
        .pwrite         (pwrite),
        .paddr          (paddr),
        .pwdata         (pwdata),
        .prdata         (prdata),
        .pready         (pready),
        .pixel_valid    (pixel_valid),
        .pixel_stall    (pixel_stall),
        .blue_delta     (blue_delta),
        .green_delta    (green_delta),
        .red_delta      (red_delta),
        .alpha_delta    (alpha_delta),
        .image_start    (image_start),
        .result_valid   (result_valid),
        .result_stall   (result_stall),
        .red_out        (red_out),
        .green_out      (green_out),
        .blue_out       (blue_out),
        .alpha_out      (alpha_out),
        .last_pixel     (last_pixel),
        .overflow_error (overflow_error)
    );

    pixel_scoreboard sb = new();

    // Random gaps/stalls on both sides; cleared for whole phases to get
    // back-to-back stretches as well.
    bit idle_on;

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Hard stop in case the block hangs; far above the slowest legal run
    initial
    begin
        #2_000_000;
        $display("** planar_delta_pixel_reconstruct_unit: FAILED **");
        $finish;
    end

    // ------------------------------------------------------------------------
    // Result side: random stall before each result, then take it
    // ------------------------------------------------------------------------
    initial
    begin
        int unsigned hold;
        result_stall <= 1'b0;
        @(posedge clk);
        while (!rst_n)
            @(posedge clk);
        forever
        begin
            hold = idle_on ? $urandom_range(0, 6) : 0;
            if (hold > 0)
            begin
                result_stall <= 1'b1;
                repeat (hold) @(posedge clk);
            end
            result_stall <= 1'b0;
            do
                @(posedge clk);
            while (!(result_valid && !result_stall));
        end
    end

    // Values read at the edge are the pre-edge ones: all drivers use NBAs
    always @(posedge clk)
    begin
        if (rst_n && result_valid && !result_stall)
            sb.check_result('{red: red_out, green: green_out, blue: blue_out,
                              alpha: alpha_out, last: last_pixel,
                              ovf: overflow_error});
    end

    // ------------------------------------------------------------------------
    // Request side
    // ------------------------------------------------------------------------

    // One pixel request: optional gap, then hold until accepted. A request
    // that would read a line store slot never written since reset (only
    // after the width grows mid-image) is turned into an image start.
    task automatic send_pixel(logic [LANE_W-1:0] b, logic [LANE_W-1:0] g,
                              logic [LANE_W-1:0] r, logic [LANE_W-1:0] a,
                              bit start);
        int unsigned gap;
        gap = idle_on ? $urandom_range(0, 6) : 0;
        if (gap > 0)
        begin
            pixel_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        if (sb.hits_blank_line(start))
            start = 1'b1;
        pixel_valid <= 1'b1;
        blue_delta  <= b;
        green_delta <= g;
        red_delta   <= r;
        alpha_delta <= a;
        image_start <= start;
        do
            @(posedge clk);
        while (pixel_stall);
        sb.note_request(b, g, r, a, start);
    endtask

    // Drop valid and hold off until every predicted pixel has come back.
    // Always waits on a clock edge so the next drive lands on a new step.
    task automatic wait_idle();
        pixel_valid <= 1'b0;
        do
            @(posedge clk);
        while (sb.pending() != 0);
    endtask

    task automatic write_reg(reg_index_t idx, logic [APB_DATA_W-1:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(posedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        sb.set_reg(idx, value);
    endtask

    // Geometry changes only with the pipe empty
    task automatic set_image(int unsigned w, int unsigned h, bit alpha);
        wait_idle();
        write_reg(REG_IMAGE_WIDTH, w);
        write_reg(REG_IMAGE_HEIGHT, h);
        write_reg(REG_USE_ALPHA, APB_DATA_W'(alpha));
    endtask

    function automatic logic [LANE_W-1:0] pick_byte();
        case ($urandom_range(0, 7))
            0:       return '0;
            1:       return '1;
            default: return LANE_W'($urandom_range(0, 255));
        endcase
    endfunction

    task automatic send_random(bit start);
        send_pixel(pick_byte(), pick_byte(), pick_byte(), pick_byte(), start);
    endtask

    // ------------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------------
    initial
    begin
        int unsigned w, h, count, sent;
        longint unsigned area;
        bit alpha, fresh;

        rst_n       <= 1'b0;
        psel        <= 1'b0;
        penable     <= 1'b0;
        pwrite      <= 1'b0;
        paddr       <= '0;
        pwdata      <= '0;
        pixel_valid <= 1'b0;
        blue_delta  <= '0;
        green_delta <= '0;
        red_delta   <= '0;
        alpha_delta <= '0;
        image_start <= 1'b0;
        idle_on     = 1'b1;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // --- directed ---
        // 3x2 image with alpha: byte extremes, last pixel, then two pixels
        // past the end, then a restart
        set_image(3, 2, 1'b1);
        send_pixel(8'hFF, 8'hFF, 8'hFF, 8'hFF, 1'b1);
        send_pixel(8'h00, 8'h00, 8'h00, 8'h00, 1'b0);
        send_pixel(8'hFF, 8'h00, 8'hFF, 8'h00, 1'b0);
        send_pixel(8'h00, 8'hFF, 8'h00, 8'hFF, 1'b0);
        send_pixel(8'h80, 8'h7F, 8'h01, 8'hFE, 1'b0);
        send_pixel(8'hAA, 8'h55, 8'hC3, 8'h3C, 1'b0);
        send_pixel(8'h12, 8'h34, 8'h56, 8'h78, 1'b0);
        send_pixel(8'hFF, 8'hFF, 8'hFF, 8'hFF, 1'b0);
        send_pixel(8'h01, 8'h02, 8'h03, 8'h04, 1'b1);
        // alpha switched off mid-image: alpha plane ignored, out forced opaque
        set_image(3, 2, 1'b0);
        send_pixel(8'h10, 8'h20, 8'h30, 8'h40, 1'b0);
        send_pixel(8'hF0, 8'hE0, 8'hD0, 8'hC0, 1'b0);
        // width cut mid-row: column past the new width wraps to the next row
        set_image(4, 3, 1'b1);
        send_pixel(8'h11, 8'h22, 8'h33, 8'h44, 1'b1);
        send_pixel(8'h55, 8'h66, 8'h77, 8'h88, 1'b0);
        send_pixel(8'h99, 8'hAA, 8'hBB, 8'hCC, 1'b0);
        set_image(2, 3, 1'b1);
        send_pixel(8'hDD, 8'hEE, 8'hFF, 8'h00, 1'b0);
        send_pixel(8'h01, 8'hFF, 8'h01, 8'hFF, 1'b0);
        // zero width, then zero height: everything overflows
        set_image(0, 5, 1'b1);
        send_pixel(8'hFF, 8'hFF, 8'hFF, 8'hFF, 1'b1);
        send_pixel(8'h5A, 8'hA5, 8'h5A, 8'hA5, 1'b0);
        set_image(5, 0, 1'b0);
        send_pixel(8'h33, 8'h44, 8'h55, 8'h66, 1'b1);
        // widest register value saturates to the line store size
        set_image(8191, 65535, 1'b1);
        send_pixel(8'hFF, 8'h01, 8'hFF, 8'h01, 1'b1);
        send_pixel(8'hFF, 8'hFF, 8'hFF, 8'hFF, 1'b0);
        send_pixel(8'h00, 8'h00, 8'h00, 8'h00, 1'b0);
        send_pixel(8'h7F, 8'h80, 8'h7F, 8'h80, 1'b0);

        // --- random phases: mostly complete small images ---
        sent = 0;
        while (sent < RANDOM_ITEMS)
        begin
            case ($urandom_range(0, 19))
                0:       w = 0;
                1:       w = LINE_DEPTH;
                2:       w = $urandom_range(LINE_DEPTH + 1, 8191);
                3, 4:    w = $urandom_range(9, 64);
                default: w = $urandom_range(1, 8);
            endcase
            case ($urandom_range(0, 19))
                0:       h = 0;
                1:       h = 65535;
                2, 3:    h = $urandom_range(7, 40);
                default: h = $urandom_range(1, 6);
            endcase
            alpha = 1'($urandom_range(0, 1));
            set_image(w, h, alpha);
            idle_on = ($urandom_range(0, 3) != 0);
            area  = longint'(w) * longint'(h);
            count = (area == 0) ? $urandom_range(1, 4)
                                : ((area > PHASE_CAP) ? PHASE_CAP : int'(area));
            // some phases run a few pixels past the end of the image
            if ($urandom_range(0, 3) == 0)
                count += $urandom_range(1, 3);
            if (count > RANDOM_ITEMS - sent)
                count = RANDOM_ITEMS - sent;
            // most phases open a new image; the rest carry the old counters
            fresh = ($urandom_range(0, 5) != 0);
            for (int i = 0; i < count; i++)
            begin
                if ($urandom_range(0, 99) == 0)
                    wait_idle();
                send_random((i == 0 && fresh) || $urandom_range(0, 39) == 0);
            end
            sent += count;
        end

        // drain, then allow the pipe to settle
        wait_idle();
        repeat (8) @(posedge clk);
        if (sb.errors == 0 && sb.pending() == 0)
            $display("** planar_delta_pixel_reconstruct_unit: PASSED **");
        else
            $display("** planar_delta_pixel_reconstruct_unit: FAILED **");
        $finish;
    end

endmodule
